// ===== rtl/tchp_pkg.sv =====
// Shared constants and types for the trace-context header parser.
`default_nettype none

package tchp_pkg;

   localparam int unsigned CharWidth = 8;
   localparam int unsigned IdWidth   = 64;
   localparam int unsigned PosWidth  = 6;

   // Header layout, in character positions after the leading blanks
   localparam logic [PosWidth-1:0] HdrLen      = 6'd55;
   localparam logic [PosWidth-1:0] PosVerHi    = 6'd0;
   localparam logic [PosWidth-1:0] PosVerLo    = 6'd1;
   localparam logic [PosWidth-1:0] PosDash0    = 6'd2;
   localparam logic [PosWidth-1:0] PosTraceLo  = 6'd3;
   localparam logic [PosWidth-1:0] PosTraceMd  = 6'd19;
   localparam logic [PosWidth-1:0] PosTraceHi  = 6'd34;
   localparam logic [PosWidth-1:0] PosDash1    = 6'd35;
   localparam logic [PosWidth-1:0] PosParLo    = 6'd36;
   localparam logic [PosWidth-1:0] PosParHi    = 6'd51;
   localparam logic [PosWidth-1:0] PosDash2    = 6'd52;

   // ASCII codes
   localparam logic [CharWidth-1:0] ChDash  = 8'h2D;
   localparam logic [CharWidth-1:0] ChSpace = 8'h20;
   localparam logic [CharWidth-1:0] ChTab   = 8'h09;
   localparam logic [CharWidth-1:0] ChZero  = 8'h30;
   localparam logic [CharWidth-1:0] ChNine  = 8'h39;
   localparam logic [CharWidth-1:0] ChLowA  = 8'h61;
   localparam logic [CharWidth-1:0] ChLowF  = 8'h66;
   localparam logic [CharWidth-1:0] ChUpA   = 8'h41;
   localparam logic [CharWidth-1:0] ChUpF   = 8'h46;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] nib;
      logic       is_dash;
      logic       is_blank;
   } char_class_type;

   typedef struct packed {
      logic               valid_res;
      logic [IdWidth-1:0] trace_high;
      logic [IdWidth-1:0] trace_low;
      logic [IdWidth-1:0] parent_span;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/tchp_char_decode.sv =====
// Character classifier: hex digit value, dash and blank detection.
`default_nettype none

module tchp_char_decode (
   input  wire logic [tchp_pkg::CharWidth-1:0] ch,
   output tchp_pkg::char_class_type            cls
);
   import tchp_pkg::*;

   logic is_dec;
   logic is_low;
   logic is_up;

   always_comb begin
      is_dec = (ch >= ChZero) && (ch <= ChNine);
      is_low = (ch >= ChLowA) && (ch <= ChLowF);
      is_up  = (ch >= ChUpA)  && (ch <= ChUpF);

      cls.is_hex   = is_dec || is_low || is_up;
      // letters a-f / A-F have low nibble 1..6; add 9 to land on 10..15
      cls.nib      = is_dec ? ch[3:0] : 4'(ch[3:0] + 4'd9);
      cls.is_dash  = (ch == ChDash);
      cls.is_blank = (ch == ChSpace) || (ch == ChTab);
   end

endmodule

`default_nettype wire

// ===== rtl/tchp_accum.sv =====
// Header state: blank skip, position counter, id shifters and format check.
`default_nettype none

module tchp_accum (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step_en,
   input  wire logic                    end_mark,
   input  wire tchp_pkg::char_class_type cls,
   output tchp_pkg::result_type         result
);
   import tchp_pkg::*;

   logic                skip_ff,  skip_in;
   logic [PosWidth-1:0] pos_ff,   pos_in;
   logic [IdWidth-1:0]  hi_ff,    hi_in;
   logic [IdWidth-1:0]  lo_ff,    lo_in;
   logic [IdWidth-1:0]  par_ff,   par_in;
   logic                err_ff,   err_in;
   logic                ok;

   always_comb begin
      skip_in = skip_ff;
      pos_in  = pos_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      par_in  = par_ff;
      err_in  = err_ff;

      if (step_en) begin
         if (end_mark) begin
            skip_in = 1'b1;
            pos_in  = '0;
            hi_in   = '0;
            lo_in   = '0;
            par_in  = '0;
            err_in  = 1'b0;
         end else if (!(skip_ff && cls.is_blank)) begin
            skip_in = 1'b0;
            if (pos_ff < HdrLen) begin
               pos_in = pos_ff + 6'd1;
               case (pos_ff) inside
                  PosVerHi, PosVerLo: begin
                     if (!cls.is_hex) err_in = 1'b1;
                  end
                  PosDash0, PosDash1, PosDash2: begin
                     if (!cls.is_dash) err_in = 1'b1;
                  end
                  [PosTraceLo:PosTraceHi]: begin
                     if (!cls.is_hex) begin
                        err_in = 1'b1;
                     end else if (pos_ff >= PosTraceMd) begin
                        lo_in = {lo_ff[IdWidth-5:0], cls.nib};
                     end else begin
                        hi_in = {hi_ff[IdWidth-5:0], cls.nib};
                     end
                  end
                  [PosParLo:PosParHi]: begin
                     if (!cls.is_hex) err_in = 1'b1;
                     else par_in = {par_ff[IdWidth-5:0], cls.nib};
                  end
                  default: begin
                     // flag characters: not checked
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b1;
         pos_ff  <= '0;
         hi_ff   <= '0;
         lo_ff   <= '0;
         par_ff  <= '0;
         err_ff  <= 1'b0;
      end else begin
         skip_ff <= skip_in;
         pos_ff  <= pos_in;
         hi_ff   <= hi_in;
         lo_ff   <= lo_in;
         par_ff  <= par_in;
         err_ff  <= err_in;
      end
   end

   always_comb begin
      ok = (pos_ff >= HdrLen) && !err_ff && ((hi_ff | lo_ff) != '0) && (par_ff != '0);
      result.valid_res   = ok;
      result.trace_high  = ok ? hi_ff  : '0;
      result.trace_low   = ok ? lo_ff  : '0;
      result.parent_span = ok ? par_ff : '0;
   end

endmodule

`default_nettype wire

// ===== rtl/trace_context_header_parser.sv =====
// Top level of the trace-context header parser: input stage, state, result register.
//
//   channel  | ports                                   | direction | one beat carries
//   ---------+-----------------------------------------+-----------+---------------------------
//   request  | req_valid req_ready req_ch req_end_mark | in        | one character or the end
//   response | rsp_valid rsp_ready rsp_valid_res       | out       | parse result, one per end
//            | rsp_trace_high rsp_trace_low            |           |
//            | rsp_parent_span                         |           |
//
// One request beat per cycle is sustained. A beat lands in the input register,
// and from there the character decoder and the header state take it in;
// an end beat also loads the result register. Only an end beat can stall the
// input stage, and only while the result register holds an untaken response.
// Synchronous reset clears the input and result valid flags and returns the
// header state to its start (skipping blanks, position zero, ids zero, no error).
`default_nettype none

module trace_context_header_parser (
   input  wire  logic                               clock,
   input  wire  logic                               reset,

   input  wire  logic                               req_valid,
   output       logic                               req_ready,
   input  wire  logic [tchp_pkg::CharWidth-1:0]     req_ch,
   input  wire  logic                               req_end_mark,

   output       logic                               rsp_valid,
   input  wire  logic                               rsp_ready,
   output       logic                               rsp_valid_res,
   output       logic [tchp_pkg::IdWidth-1:0]       rsp_trace_high,
   output       logic [tchp_pkg::IdWidth-1:0]       rsp_trace_low,
   output       logic [tchp_pkg::IdWidth-1:0]       rsp_parent_span
);
   import tchp_pkg::*;

   // input stage
   logic                 in_vld_ff,  in_vld_in;
   logic [CharWidth-1:0] in_ch_ff;
   logic                 in_end_ff;

   // result stage
   logic                 out_vld_ff, out_vld_in;
   result_type           out_res_ff;

   char_class_type       cls;
   result_type           result;
   logic                 out_free;
   logic                 advance;
   logic                 load_out;

   // Drain the result register when taken; an end beat may refill it the same cycle.
   assign out_free  = !out_vld_ff || rsp_ready;
   assign advance   = in_vld_ff && (!in_end_ff || out_free);
   assign load_out  = advance && in_end_ff;
   assign req_ready = !in_vld_ff || advance;

   tchp_char_decode u_decode (
      .ch  (in_ch_ff),
      .cls (cls)
   );

   tchp_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .end_mark (in_end_ff),
      .cls      (cls),
      .result   (result)
   );

   always_comb begin
      in_vld_in  = req_valid || (in_vld_ff && !advance);
      out_vld_in = load_out || (out_vld_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Capture a new beat whenever the input stage can take one, else hold; load the result when an end beat advances.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff  <= req_ch;
         in_end_ff <= req_end_mark;
      end
      if (load_out) begin
         out_res_ff <= result;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_valid_res   = out_res_ff.valid_res;
   assign rsp_trace_high  = out_res_ff.trace_high;
   assign rsp_trace_low   = out_res_ff.trace_low;
   assign rsp_parent_span = out_res_ff.parent_span;

endmodule

`default_nettype wire

// ===== tb/sv/trace_context_header_checker.sv =====
// Checker for the trace-context header parser: predicts each parse result and compares it.
module trace_context_header_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [tchp_pkg::CharWidth-1:0]   req_ch,
   input  logic                             req_end_mark,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             rsp_valid_res,
   input  logic [tchp_pkg::IdWidth-1:0]     rsp_trace_high,
   input  logic [tchp_pkg::IdWidth-1:0]     rsp_trace_low,
   input  logic [tchp_pkg::IdWidth-1:0]     rsp_parent_span,
   output int unsigned                      mismatch_count,
   output int unsigned                      results_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import tchp_pkg::*;

   logic                 in_leading_blanks;
   logic [PosWidth-1:0]  header_pos;
   logic [IdWidth-1:0]   trace_id_high;
   logic [IdWidth-1:0]   trace_id_low;
   logic [IdWidth-1:0]   parent_id;
   logic                 header_bad;
   result_type           parse_results[$];

   // MSB flags a hex digit, low nibble holds its value
   function automatic logic [4:0] hex_digit(input logic [CharWidth-1:0] c);
      if (c >= ChZero && c <= ChNine) return {1'b1, 4'(c - ChZero)};
      if (c >= ChLowA && c <= ChLowF) return {1'b1, 4'(c - ChLowA + 8'd10)};
      if (c >= ChUpA && c <= ChUpF) return {1'b1, 4'(c - ChUpA + 8'd10)};
      return 5'd0;
   endfunction

   task automatic clear_header();
      in_leading_blanks = 1'b1;
      header_pos        = '0;
      trace_id_high     = '0;
      trace_id_low      = '0;
      parent_id         = '0;
      header_bad        = 1'b0;
   endtask

   task automatic absorb_char(input logic [CharWidth-1:0] c);
      logic [4:0] digit;
      digit = hex_digit(c);
      if (in_leading_blanks && (c == ChSpace || c == ChTab)) return;
      in_leading_blanks = 1'b0;
      if (header_pos >= HdrLen) return;
      if (header_pos == PosVerHi || header_pos == PosVerLo) begin
         if (!digit[4]) header_bad = 1'b1;
      end else if (header_pos == PosDash0 || header_pos == PosDash1 || header_pos == PosDash2) begin
         if (c != ChDash) header_bad = 1'b1;
      end else if (header_pos >= PosTraceLo && header_pos <= PosTraceHi) begin
         if (!digit[4]) header_bad = 1'b1;
         else if (header_pos >= PosTraceMd) trace_id_low = {trace_id_low[IdWidth-5:0], digit[3:0]};
         else trace_id_high = {trace_id_high[IdWidth-5:0], digit[3:0]};
      end else if (header_pos >= PosParLo && header_pos <= PosParHi) begin
         if (!digit[4]) header_bad = 1'b1;
         else parent_id = {parent_id[IdWidth-5:0], digit[3:0]};
      end
      header_pos = header_pos + 6'd1;
   endtask

   task automatic close_header();
      result_type r;
      r = '0;
      r.valid_res = header_pos >= HdrLen && !header_bad &&
                    (trace_id_high | trace_id_low) != '0 && parent_id != '0;
      if (r.valid_res) begin
         r.trace_high  = trace_id_high;
         r.trace_low   = trace_id_low;
         r.parent_span = parent_id;
      end
      parse_results.push_back(r);
      clear_header();
   endtask

   task automatic compare_field(input string field, input logic [IdWidth-1:0] want,
                                input logic [IdWidth-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         clear_header();
         parse_results.delete();
      end else begin
         // response side first: an end beat taken at this edge cannot answer yet
         if (rsp_valid && rsp_ready) begin
            if (parse_results.size() == 0) begin
               $display("%0t: unexpected response beat: expected none actual %b %h %h %h",
                        $time, rsp_valid_res, rsp_trace_high, rsp_trace_low, rsp_parent_span);
               mismatch_count++;
            end else begin
               want = parse_results.pop_front();
               compare_field("valid_res", IdWidth'(want.valid_res), IdWidth'(rsp_valid_res));
               compare_field("trace_high", want.trace_high, rsp_trace_high);
               compare_field("trace_low", want.trace_low, rsp_trace_low);
               compare_field("parent_span", want.parent_span, rsp_parent_span);
            end
         end
         if (req_valid && req_ready) begin
            if (req_end_mark) close_header();
            else absorb_char(req_ch);
         end
      end
      results_outstanding = parse_results.size();
   end

endmodule

// ===== tb/sv/tb_trace_context_header_parser.sv =====
// Testbench top for the trace-context header parser: stimulus, clock, reset and verdict.
module tb_trace_context_header_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import tchp_pkg::*;

   localparam int unsigned CycleLimit   = 400000;
   localparam int unsigned BeatTarget   = 1600;
   localparam int unsigned HeaderTarget = 24;
   localparam int unsigned IdlePercent  = 9;
   localparam int unsigned DrainCycles  = 10;
   localparam logic [CharWidth-1:0] ChNul = 8'h00;

   typedef enum int {CaseLower, CaseUpper, CaseMixed} letter_case_type;
   typedef enum int {HdrClean, HdrCorrupt, HdrTruncated, HdrBlankInside, HdrNoise} header_shape_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [CharWidth-1:0]  req_ch;
   logic                  req_end_mark;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_valid_res;
   logic [IdWidth-1:0]    rsp_trace_high;
   logic [IdWidth-1:0]    rsp_trace_low;
   logic [IdWidth-1:0]    rsp_parent_span;

   int unsigned           mismatch_count;
   int unsigned           results_outstanding;
   int unsigned           beats_sent;
   int unsigned           headers_sent;
   bit                    steady_flow;
   logic [CharWidth-1:0]  header_chars[$];

   trace_context_header_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .req_end_mark    (req_end_mark),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_trace_high  (rsp_trace_high),
      .rsp_trace_low   (rsp_trace_low),
      .rsp_parent_span (rsp_parent_span)
   );

   trace_context_header_checker checker_inst (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_ch              (req_ch),
      .req_end_mark        (req_end_mark),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_valid_res       (rsp_valid_res),
      .rsp_trace_high      (rsp_trace_high),
      .rsp_trace_low       (rsp_trace_low),
      .rsp_parent_span     (rsp_parent_span),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hold back rsp_ready about 9 percent of the time, except during the steady stretch.
   always @(negedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(0, 99) >= IdlePercent);
   end

   // Stop a hung run: a cycle counter with a generous ceiling.
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_trace_context_header_parser failed");
      $finish;
   end

   // One hex character for digit d; letters come out in the requested case.
   function automatic logic [CharWidth-1:0] hex_char(input logic [3:0] d,
                                                     input letter_case_type lc);
      bit upper;
      upper = (lc == CaseUpper) || (lc == CaseMixed && $urandom_range(0, 1) == 1);
      if (d < 4'd10) return ChZero + 8'(d);
      return (upper ? ChUpA : ChLowA) + 8'(d - 4'd10);
   endfunction

   // Build a well-formed 55-character body plus tail_len arbitrary trailing characters.
   // Either id can be forced to all zero.
   task automatic compose_traceparent(input letter_case_type lc, input bit zero_trace,
                                      input bit zero_parent, input int unsigned tail_len);
      header_chars.delete();
      repeat (2) header_chars.push_back(hex_char(4'($urandom_range(0, 15)), lc));
      header_chars.push_back(ChDash);
      repeat (32) header_chars.push_back(hex_char(zero_trace ? 4'd0 : 4'($urandom_range(0, 15)), lc));
      header_chars.push_back(ChDash);
      repeat (16) header_chars.push_back(hex_char(zero_parent ? 4'd0 : 4'($urandom_range(0, 15)), lc));
      header_chars.push_back(ChDash);
      // flags are never checked, so let them be anything
      repeat (2) header_chars.push_back(8'($urandom_range(0, 255)));
      repeat (tail_len) header_chars.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_leading_blanks(input int unsigned count);
      repeat (count) header_chars.push_front($urandom_range(0, 1) ? ChSpace : ChTab);
   endtask

   // Drive one request beat: idle at random first, then hold valid and payload until taken.
   task automatic send_beat(input logic [CharWidth-1:0] c, input logic closing);
      while (!steady_flow && $urandom_range(0, 99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_ch       <= c;
      req_end_mark <= closing;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   // Send every character of the header, then the end beat with a junk character.
   task automatic send_header();
      foreach (header_chars[i]) send_beat(header_chars[i], 1'b0);
      send_beat(8'($urandom_range(0, 255)), 1'b1);
      headers_sent++;
      steady_flow = headers_sent >= 14 && headers_sent < 22;
   endtask

   initial begin
      header_shape_type shape;
      int unsigned      count;
      int unsigned      idx;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_ch       = '0;
      req_end_mark = 1'b0;
      beats_sent   = 0;
      headers_sent = 0;
      steady_flow  = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed headers ----
      // empty header: just the end beat
      header_chars.delete();
      send_header();
      // only blanks, then the end
      header_chars = '{ChSpace, ChTab, ChSpace};
      send_header();
      // clean lowercase header, exactly 55 characters
      compose_traceparent(CaseLower, 1'b0, 1'b0, 0);
      send_header();
      // uppercase, leading blanks, long tail that must be ignored
      compose_traceparent(CaseUpper, 1'b0, 1'b0, 6);
      add_leading_blanks(2);
      send_header();
      // all-zero trace id
      compose_traceparent(CaseMixed, 1'b1, 1'b0, 0);
      send_header();
      // all-zero parent id
      compose_traceparent(CaseMixed, 1'b0, 1'b1, 1);
      send_header();
      // short header: one character missing
      compose_traceparent(CaseLower, 1'b0, 1'b0, 0);
      void'(header_chars.pop_back());
      send_header();
      // hex digit where the middle dash belongs
      compose_traceparent(CaseMixed, 1'b0, 1'b0, 0);
      header_chars[PosDash1] = ChZero;
      send_header();
      // blank where the final dash belongs
      compose_traceparent(CaseMixed, 1'b0, 1'b0, 0);
      header_chars[PosDash2] = ChSpace;
      send_header();
      // zero character inside the trace id
      compose_traceparent(CaseLower, 1'b0, 1'b0, 0);
      header_chars[PosTraceLo + 4] = ChNul;
      send_header();
      // tab inside the header after the leading blanks are over
      compose_traceparent(CaseLower, 1'b0, 1'b0, 0);
      header_chars[PosTraceMd + 1] = ChTab;
      add_leading_blanks(1);
      send_header();
      // version digit with the top bit set
      compose_traceparent(CaseUpper, 1'b0, 1'b0, 0);
      header_chars[PosVerHi] = 8'hFF;
      send_header();
      // dash in the second version position, non-hex letter in the parent id
      compose_traceparent(CaseLower, 1'b0, 1'b0, 0);
      header_chars[PosVerLo] = ChDash;
      send_header();
      compose_traceparent(CaseLower, 1'b0, 1'b0, 0);
      header_chars[PosParHi] = ChUpF + 8'd1;
      send_header();

      // ---- random headers ----
      // Mostly well-formed headers with random content; the rest broken or noise.
      while (beats_sent < BeatTarget || headers_sent < HeaderTarget) begin
         count = $urandom_range(0, 99);
         shape = count < 55 ? HdrClean :
                 count < 70 ? HdrCorrupt :
                 count < 82 ? HdrTruncated :
                 count < 88 ? HdrBlankInside : HdrNoise;
         compose_traceparent(letter_case_type'($urandom_range(0, 2)),
                             $urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0,
                             $urandom_range(0, 3));
         case (shape)
            HdrCorrupt: begin
               idx = $urandom_range(0, header_chars.size() - 1);
               header_chars[idx] = 8'($urandom_range(0, 255));
            end
            HdrTruncated: begin
               count = $urandom_range(0, HdrLen);
               while (header_chars.size() > count) void'(header_chars.pop_back());
            end
            HdrBlankInside: begin
               idx = $urandom_range(1, HdrLen - 1);
               header_chars[idx] = $urandom_range(0, 1) ? ChSpace : ChTab;
            end
            HdrNoise: begin
               header_chars.delete();
               count = $urandom_range(0, 20);
               repeat (count) header_chars.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
         endcase
         add_leading_blanks($urandom_range(0, 3));
         send_header();
      end

      // Drop valid, drain every outstanding response, then allow the pipe to settle.
      req_valid <= 1'b0;
      while (results_outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("tb_trace_context_header_parser passed");
      end else begin
         $display("tb_trace_context_header_parser failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tchp_pkg.sv
rtl/tchp_char_decode.sv
rtl/tchp_accum.sv
rtl/trace_context_header_parser.sv
tb/sv/trace_context_header_checker.sv
tb/sv/tb_trace_context_header_parser.sv
